### rtl/stc_pkg.sv
// Shared types, codes, constants and clamp and step helpers for the sun tracker servo controller.
`default_nettype none

package stc_pkg;

  localparam logic [1:0] KIND_TICK   = 2'd0;
  localparam logic [1:0] KIND_MODE   = 2'd1;
  localparam logic [1:0] KIND_MANUAL = 2'd2;
  localparam logic [1:0] KIND_SLEW   = 2'd3;

  localparam logic [1:0] MODE_AUTO   = 2'd0;
  localparam logic [1:0] MODE_MANUAL = 2'd1;
  localparam logic [1:0] MODE_CALIB  = 2'd2;
  localparam logic [1:0] MODE_DEMO   = 2'd3;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 9;
  localparam logic [CfgIdxW-1:0] CFG_MIN_TILT = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_TILT = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_AZ_OFF   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_TILT_OFF = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_AP_MODE  = 3'd4;

  localparam logic [7:0] MIN_TILT_RST = 8'd15;
  localparam logic [7:0] MAX_TILT_RST = 8'd90;
  localparam logic [7:0] POS_RST      = 8'd90;

  localparam logic [7:0] PAN_MAX  = 8'd180;
  localparam logic [7:0] PAN_MID  = 8'd90;
  localparam int unsigned DemoStep = 2;

  // Reciprocals: floor(x/10) = (x*6554)>>16 for x < 16384, floor(x/90) = (x*23302)>>21
  // for x < 74898.
  localparam int unsigned AzRecip = 6554;
  localparam int unsigned AzShift = 16;
  localparam int unsigned DemoRecip = 23302;
  localparam int unsigned DemoShift = 21;
  localparam int unsigned DemoCeilBias = 89 * DemoRecip;
  localparam int unsigned RcpW = 23;

  typedef struct packed {
    logic [7:0] auto_pan;
    logic [7:0] auto_tilt;
    logic [7:0] demo_pan;
    logic       demo_down;
    logic [7:0] demo_tilt;
  } aim_t;

  function automatic logic [7:0] clamp_pan(input logic signed [10:0] v);
    logic [7:0] r;
    if (v < 11'sd0) begin
      r = 8'd0;
    end else if (v > signed'({3'b000, PAN_MAX})) begin
      r = PAN_MAX;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

  function automatic logic [7:0] clamp_tilt(input logic signed [10:0] v,
                                            input logic [7:0] lo,
                                            input logic [7:0] hi);
    logic signed [10:0] los;
    logic signed [10:0] his;
    logic [7:0]         r;
    los = signed'({3'b000, lo});
    his = signed'({3'b000, hi});
    if (v < los) begin
      r = lo;
    end else if (v > his) begin
      r = hi;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

  function automatic logic [7:0] step_toward(input logic [7:0] cur, input logic [7:0] tgt);
    logic [7:0] r;
    if (cur < tgt) begin
      r = cur + 8'd1;
    end else if (cur > tgt) begin
      r = cur - 8'd1;
    end else begin
      r = cur;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/stc_aim.sv
// Aim arithmetic: auto pan and tilt targets and the next demo sweep point.
`default_nettype none

module stc_aim (
  input  logic [11:0]             sun_azimuth_i,
  input  logic signed [10:0]      sun_altitude_i,
  input  logic signed [8:0]       azimuth_offset_i,
  input  logic signed [7:0]       tilt_offset_i,
  input  logic [7:0]              min_tilt_i,
  input  logic [7:0]              max_tilt_i,
  input  logic [7:0]              demo_pan_i,
  input  logic                    demo_down_i,
  input  logic [stc_pkg::RcpW-1:0] demo_rcp_i,
  input  logic                    demo_neg_i,
  output stc_pkg::aim_t           aim_o
);
  import stc_pkg::*;

  logic [24:0]        az_prod;
  logic signed [10:0] pan_raw;
  logic signed [12:0] toff10;
  logic signed [12:0] alt_sum;
  logic [11:0]        alt_abs;
  logic [24:0]        alt_prod;
  logic signed [10:0] tilt_raw;
  logic signed [9:0]  dp_raw;
  logic [7:0]         dp_next;
  logic               dd_next;
  logic [7:0]         pan_dev;
  logic [29:0]        demo_prod;
  logic [29:0]        demo_sum;
  logic [7:0]         demo_q;
  logic signed [10:0] demo_raw;

  assign az_prod = {13'd0, sun_azimuth_i} * 25'(AzRecip);
  assign pan_raw = signed'({2'b00, az_prod[24:AzShift]}) - signed'({3'b000, PAN_MID})
                 + 11'(azimuth_offset_i);

  assign toff10   = (13'(tilt_offset_i) <<< 3) + (13'(tilt_offset_i) <<< 1);
  assign alt_sum  = 13'(sun_altitude_i) + toff10;
  assign alt_abs  = alt_sum[12] ? 12'(-alt_sum) : alt_sum[11:0];
  assign alt_prod = {13'd0, alt_abs} * 25'(AzRecip);
  assign tilt_raw = alt_sum[12] ? -signed'({3'b000, alt_prod[23:AzShift]})
                                :  signed'({3'b000, alt_prod[23:AzShift]});

  assign dp_raw = demo_down_i ? signed'({2'b00, demo_pan_i}) - 10'(DemoStep)
                              : signed'({2'b00, demo_pan_i}) + 10'(DemoStep);

  always_comb begin
    if (dp_raw >= signed'({2'b00, PAN_MAX})) begin
      dp_next = PAN_MAX;
      dd_next = 1'b1;
    end else if (dp_raw <= 10'sd0) begin
      dp_next = 8'd0;
      dd_next = 1'b0;
    end else begin
      dp_next = dp_raw[7:0];
      dd_next = demo_down_i;
    end
  end

  assign pan_dev   = (dp_next >= PAN_MID) ? dp_next - PAN_MID : PAN_MID - dp_next;
  assign demo_prod = {23'd0, pan_dev[6:0]} * {7'd0, demo_rcp_i};
  assign demo_sum  = demo_prod + (demo_neg_i ? 30'd0 : 30'(DemoCeilBias));
  assign demo_q    = demo_sum[DemoShift+7:DemoShift];
  assign demo_raw  = demo_neg_i ? signed'({3'b000, max_tilt_i}) + signed'({3'b000, demo_q})
                                : signed'({3'b000, max_tilt_i}) - signed'({3'b000, demo_q});

  assign aim_o.auto_pan  = clamp_pan(pan_raw);
  assign aim_o.auto_tilt = clamp_tilt(tilt_raw, min_tilt_i, max_tilt_i);
  assign aim_o.demo_pan  = dp_next;
  assign aim_o.demo_down = dd_next;
  assign aim_o.demo_tilt = clamp_tilt(demo_raw, min_tilt_i, max_tilt_i);

endmodule

`default_nettype wire

### rtl/solar_tracker_servo_controller.sv
// An accepted transaction is processed from the input register into the result register.
// One transaction per cycle while out_ready_i does not stall the output; the state registers
// update once per item in a single registered pass between the input and result registers.
// Reset: asynchronous, active low; mode auto, both axes at 90, servos enabled, no night,
// no slew, tilt range 15..90, offsets 0. Configuration writes are always accepted.
`default_nettype none

module solar_tracker_servo_controller (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [stc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [stc_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    kind_i,
  input  logic [1:0]                    mode_value_i,
  input  logic signed [9:0]             manual_hor_i,
  input  logic signed [9:0]             manual_ver_i,
  input  logic [11:0]                   sun_azimuth_i,
  input  logic signed [10:0]            sun_altitude_i,
  input  logic                          clock_valid_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [7:0]                    pan_angle_o,
  output logic [7:0]                    tilt_angle_o,
  output logic                          servos_enabled_o,
  output logic                          night_flag_o,
  output logic                          slewing_o,
  output logic                          item_ignored_o,
  output logic [1:0]                    current_mode_o
);
  import stc_pkg::*;

  logic              cfg_we;
  logic [7:0]        min_tilt_q, max_tilt_q, min_tilt_d, max_tilt_d;
  logic signed [8:0] az_off_q;
  logic signed [7:0] tilt_off_q;
  logic              ap_mode_q;
  logic signed [8:0] tilt_span;
  logic [7:0]        span_abs;
  logic [RcpW-1:0]   rcp_q, rcp_d;
  logic              dneg_q;

  logic              in_vld_q, out_vld_q, adv, fire, accept;
  logic [1:0]        kind_q, mode_value_q;
  logic signed [9:0] hor_q, ver_q;
  logic [11:0]       az_q;
  logic signed [10:0] alt_q;
  logic              cv_q;

  logic [1:0]        mode_q, mode_d;
  logic [7:0]        pan_q, pan_d, tilt_q, tilt_d, dpan_q, dpan_d;
  logic              ddown_q, ddown_d, night_q, night_d, en_q, en_d, slew_q, slew_d;
  logic [7:0]        spt_q, spt_d, stt_q, stt_d;
  logic              ign_d;

  logic [7:0]        out_pan_q, out_tilt_q;
  logic              out_en_q, out_night_q, out_slew_q, out_ign_q;
  logic [1:0]        out_mode_q;

  aim_t              aim;

  // Configuration path; the demo tilt reciprocal is refreshed with every tilt range write.
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i;
  assign min_tilt_d  = (cfg_index_i == CFG_MIN_TILT) ? cfg_data_i[7:0] : min_tilt_q;
  assign max_tilt_d  = (cfg_index_i == CFG_MAX_TILT) ? cfg_data_i[7:0] : max_tilt_q;
  assign tilt_span   = signed'({1'b0, max_tilt_d}) - signed'({1'b0, min_tilt_d});
  assign span_abs    = tilt_span[8] ? 8'(-tilt_span) : tilt_span[7:0];
  assign rcp_d       = {15'd0, span_abs} * RcpW'(DemoRecip);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_tilt_q <= MIN_TILT_RST;
      max_tilt_q <= MAX_TILT_RST;
      az_off_q   <= '0;
      tilt_off_q <= '0;
      ap_mode_q  <= 1'b0;
      rcp_q      <= RcpW'(DemoRecip * (MAX_TILT_RST - MIN_TILT_RST));
      dneg_q     <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index_i) inside
        CFG_MIN_TILT, CFG_MAX_TILT: begin
          min_tilt_q <= min_tilt_d;
          max_tilt_q <= max_tilt_d;
          rcp_q      <= rcp_d;
          dneg_q     <= tilt_span[8];
        end
        CFG_AZ_OFF:   az_off_q   <= signed'(cfg_data_i);
        CFG_TILT_OFF: tilt_off_q <= signed'(cfg_data_i[7:0]);
        CFG_AP_MODE:  ap_mode_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Input register and output register handshake.
  assign adv        = !out_vld_q || out_ready_i;
  assign fire       = in_vld_q && adv;
  assign in_ready_o = !in_vld_q || adv;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (accept) begin
        in_vld_q <= 1'b1;
      end else if (adv) begin
        in_vld_q <= 1'b0;
      end
      if (fire) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q       <= kind_i;
      mode_value_q <= mode_value_i;
      hor_q        <= manual_hor_i;
      ver_q        <= manual_ver_i;
      az_q         <= sun_azimuth_i;
      alt_q        <= sun_altitude_i;
      cv_q         <= clock_valid_i;
    end
  end

  stc_aim u_aim (
    .sun_azimuth_i    (az_q),
    .sun_altitude_i   (alt_q),
    .azimuth_offset_i (az_off_q),
    .tilt_offset_i    (tilt_off_q),
    .min_tilt_i       (min_tilt_q),
    .max_tilt_i       (max_tilt_q),
    .demo_pan_i       (dpan_q),
    .demo_down_i      (ddown_q),
    .demo_rcp_i       (rcp_q),
    .demo_neg_i       (dneg_q),
    .aim_o            (aim)
  );

  always_comb begin
    mode_d  = mode_q;
    pan_d   = pan_q;
    tilt_d  = tilt_q;
    dpan_d  = dpan_q;
    ddown_d = ddown_q;
    night_d = night_q;
    en_d    = en_q;
    slew_d  = slew_q;
    spt_d   = spt_q;
    stt_d   = stt_q;
    ign_d   = 1'b0;
    unique case (kind_q)
      KIND_SLEW: begin
        if (slew_q) begin
          pan_d  = step_toward(pan_q, spt_q);
          tilt_d = step_toward(tilt_q, stt_q);
          if (pan_d == spt_q && tilt_d == stt_q) begin
            slew_d = 1'b0;
          end
        end
      end
      KIND_TICK: begin
        if (slew_q) begin
          ign_d = 1'b1;
        end else if (mode_q != MODE_AUTO) begin
          night_d = 1'b0;
          en_d    = 1'b1;
          if (mode_q == MODE_CALIB) begin
            pan_d  = PAN_MID;
            tilt_d = clamp_tilt(signed'({3'b000, PAN_MID}), min_tilt_q, max_tilt_q);
          end else if (mode_q == MODE_DEMO) begin
            dpan_d  = aim.demo_pan;
            ddown_d = aim.demo_down;
            pan_d   = aim.demo_pan;
            tilt_d  = aim.demo_tilt;
          end
        end else if (cv_q && !ap_mode_q) begin
          if (alt_q <= 11'sd0) begin
            if (!night_q) begin
              night_d = 1'b1;
              en_d    = 1'b0;
            end
          end else if (night_q) begin
            night_d = 1'b0;
            en_d    = 1'b1;
            spt_d   = aim.auto_pan;
            stt_d   = aim.auto_tilt;
            slew_d  = (pan_q != aim.auto_pan) || (tilt_q != aim.auto_tilt);
          end else begin
            en_d   = 1'b1;
            pan_d  = aim.auto_pan;
            tilt_d = aim.auto_tilt;
          end
        end
      end
      KIND_MODE: begin
        if (slew_q) begin
          ign_d = 1'b1;
        end else begin
          mode_d = mode_value_q;
          if (mode_value_q == MODE_DEMO) begin
            dpan_d  = 8'd0;
            ddown_d = 1'b0;
            en_d    = 1'b1;
            pan_d   = 8'd0;
            tilt_d  = clamp_tilt(signed'({3'b000, min_tilt_q}), min_tilt_q, max_tilt_q);
          end
        end
      end
      KIND_MANUAL: begin
        if (slew_q) begin
          ign_d = 1'b1;
        end else if (mode_q == MODE_MANUAL) begin
          en_d   = 1'b1;
          pan_d  = clamp_pan(11'(hor_q));
          tilt_d = clamp_tilt(11'(ver_q), min_tilt_q, max_tilt_q);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_AUTO;
      pan_q   <= POS_RST;
      tilt_q  <= POS_RST;
      dpan_q  <= 8'd0;
      ddown_q <= 1'b0;
      night_q <= 1'b0;
      en_q    <= 1'b1;
      slew_q  <= 1'b0;
      spt_q   <= 8'd0;
      stt_q   <= 8'd0;
    end else if (fire) begin
      mode_q  <= mode_d;
      pan_q   <= pan_d;
      tilt_q  <= tilt_d;
      dpan_q  <= dpan_d;
      ddown_q <= ddown_d;
      night_q <= night_d;
      en_q    <= en_d;
      slew_q  <= slew_d;
      spt_q   <= spt_d;
      stt_q   <= stt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_pan_q   <= pan_d;
      out_tilt_q  <= tilt_d;
      out_en_q    <= en_d;
      out_night_q <= night_d;
      out_slew_q  <= slew_d;
      out_ign_q   <= ign_d;
      out_mode_q  <= mode_d;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign pan_angle_o      = out_pan_q;
  assign tilt_angle_o     = out_tilt_q;
  assign servos_enabled_o = out_en_q;
  assign night_flag_o     = out_night_q;
  assign slewing_o        = out_slew_q;
  assign item_ignored_o   = out_ign_q;
  assign current_mode_o   = out_mode_q;

  // A slew only starts with the servos enabled, and nothing disables them during it.
  a_slew_enabled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slew_q |-> en_q) else $error("slew active with servos disabled");

  // A dropped transaction can only be reported while a slew is running.
  a_ignored_slewing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_ign_q) |-> out_slew_q) else $error("ignored item outside a slew");

  a_pan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pan_q <= PAN_MAX) else $error("pan position out of range");

  // Every item leaving the input register lands in the result register.
  a_fire_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_vld_q) else $error("processed item produced no result");

endmodule

`default_nettype wire
